/* hdl/nalsplit_pkg.sv */
// Types, constants and start code helper for the Annex B NAL unit splitter.
package nalsplit_pkg;

	localparam int unsigned WIN_BYTES = 5;
	localparam int unsigned PKT_W = 17;

	localparam logic [7:0] SC_MARK = 8'h01;
	localparam logic [2:0] SC_LONG = 3'd4;
	localparam logic [2:0] SC_SHORT = 3'd3;
	localparam logic [2:0] SC_NONE = 3'd0;
	// Bytes that remain readable while more input is still to come.
	localparam logic [2:0] AHEAD = 3'd6;

	localparam logic [4:0] TYPE_NON_IDR = 5'd1;
	localparam logic [4:0] TYPE_IDR = 5'd5;

	localparam logic [PKT_W-1:0] MAX_PKT_RESET = 17'd4096;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_NO_START = 2'd1,
		ERR_END_START = 2'd2,
		ERR_ADJ_START = 2'd3
	} err_code_t;

	typedef struct packed {
		logic [7:0] data;
		logic unit_first;
		logic unit_last;
		logic packet_first;
		logic packet_last;
		logic [4:0] unit_type;
		logic has_stamp;
		logic [31:0] stamp;
		err_code_t error;
		logic stream_end;
		logic run_last;
	} res_t;

	// Length of a start code that begins at b0, given r readable bytes.
	function automatic logic [2:0] code_len(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic [2:0] r);
		logic zero2;
		zero2 = (b0 == 8'h00) && (b1 == 8'h00);
		if (r >= SC_LONG && zero2 && b2 == 8'h00 && b3 == SC_MARK) begin
			return SC_LONG;
		end else if (r >= SC_SHORT && zero2 && b2 == SC_MARK) begin
			return SC_SHORT;
		end else begin
			return SC_NONE;
		end
	endfunction

endpackage

/* hdl/annexb_nal_unit_splitter.sv */
// Annex B byte stream splitter that marks NAL unit and packet boundaries.
//
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_byte, in_last
// out     | output    | out_valid/out_stall| out_byte, unit/packet marks, stamp, error_code
// cfg     | input     | cfg_valid/cfg_ready| cfg_data (max_packet_bytes)
//
// One byte is taken per cycle while in_stall is low. The first four bytes of a stream fill
// the lookahead window and give no result; after that each byte gives one result, shown in
// the cycle after it is taken. The final byte flushes the window: it gives up to five
// results, one per cycle while out_stall allows, and in_stall stays high until every byte
// held in the window (at most 4) has given its result; it also follows out_stall while the
// output register is full. Reset clears the window, the stamp counter and the sticky error;
// max_packet_bytes resets to 4096.
module annexb_nal_unit_splitter import nalsplit_pkg::*; #(
	parameter int unsigned STAMP_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        unit_first,
	output logic        unit_last,
	output logic        packet_first,
	output logic        packet_last,
	output logic [4:0]  unit_type,
	output logic        has_stamp,
	output logic [31:0] stamp,
	output logic [1:0]  error_code,
	output logic        stream_end,
	output logic        run_last
);

	logic [WIN_BYTES-1:0][7:0] win_q, vw;
	logic [2:0] fill_q, vfill, rem, r1, cl0, cl1;
	logic flush_q, fin, last_out;
	logic sas_q, sas_d;
	logic [2:0] scl_q, scl_d;
	logic [PKT_W-1:0] pkt_q, pkt_d, lim, maxp_q;
	logic [PKT_W:0] pkt_inc;
	logic [STAMP_WIDTH-1:0] ctr_q, ctr_d;
	logic [STAMP_WIDTH+31:0] ctr_ext;
	err_code_t sticky_q, sticky_d;
	logic [4:0] hdr;
	logic err, ulast;
	logic out_free, accept, emit_en;
	res_t res, res_q;
	logic out_valid_q;

	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = flush_q || !out_free;
	assign accept = in_valid && !in_stall;
	assign emit_en = (flush_q && out_free) || (accept && (in_last || fill_q == 3'd4));

	assign fin = flush_q || in_last;
	assign vfill = flush_q ? fill_q : fill_q + 3'd1;
	assign rem = fin ? vfill : AHEAD;
	assign r1 = rem - 3'd1;
	assign last_out = fin && (vfill == 3'd1);
	assign ctr_ext = {32'd0, ctr_q};
	assign lim = (maxp_q == '0) ? PKT_W'(1) : maxp_q;

	// The window as seen this cycle: during a flush the stored bytes, otherwise the
	// stored bytes with the incoming byte placed behind them.
	always_comb begin
		vw = win_q;
		if (!flush_q) begin
			for (int i = 0; i < WIN_BYTES; i++) begin
				if (fill_q == 3'(i)) begin
					vw[i] = in_byte;
				end
			end
		end
	end

	assign cl0 = code_len(vw[0], vw[1], vw[2], vw[3], rem);
	assign cl1 = code_len(vw[1], vw[2], vw[3], vw[4], r1);

	always_comb begin
		res = '0;
		res.data = vw[0];
		sas_d = sas_q;
		scl_d = scl_q;
		pkt_d = pkt_q;
		ctr_d = ctr_q;
		sticky_d = sticky_q;
		err = 1'b0;
		ulast = 1'b0;
		hdr = '0;
		pkt_inc = {1'b0, pkt_q} + 18'd1;
		if (sticky_q == ERR_NONE) begin
			if (sas_q) begin
				if (cl0 == SC_NONE) begin
					sticky_d = ERR_NO_START;
					err = 1'b1;
				end else begin
					sas_d = 1'b0;
					scl_d = cl0;
					res.unit_first = 1'b1;
					if (rem > cl0) begin
						hdr = (cl0 == SC_LONG) ? vw[4][4:0] : vw[3][4:0];
					end
					res.unit_type = hdr;
					if (hdr == TYPE_NON_IDR || hdr == TYPE_IDR) begin
						res.has_stamp = 1'b1;
						res.stamp = ctr_ext[31:0];
						ctr_d = ctr_q + STAMP_WIDTH'(1);
					end
				end
			end
			if (!err) begin
				if (scl_d != 3'd0) begin
					scl_d = scl_d - 3'd1;
					if (scl_d == 3'd0) begin
						if (r1 == 3'd0) begin
							sticky_d = ERR_END_START;
							err = 1'b1;
						end else if (cl1 != SC_NONE) begin
							sticky_d = ERR_ADJ_START;
							err = 1'b1;
						end
					end
				end else if (r1 == 3'd0 || cl1 != SC_NONE) begin
					ulast = 1'b1;
					sas_d = 1'b1;
				end
			end
			if (!err) begin
				res.unit_last = ulast;
				res.packet_first = (pkt_q == '0);
				if (pkt_inc >= {1'b0, lim} || ulast) begin
					res.packet_last = 1'b1;
					pkt_d = '0;
				end else begin
					pkt_d = pkt_inc[PKT_W-1:0];
				end
			end else begin
				res.unit_first = 1'b0;
				res.unit_type = '0;
				res.has_stamp = 1'b0;
				res.stamp = '0;
			end
		end
		res.error = sticky_d;
		res.stream_end = last_out;
		res.run_last = !fin || last_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			fill_q <= '0;
			flush_q <= 1'b0;
			sas_q <= 1'b1;
			scl_q <= '0;
			pkt_q <= '0;
			ctr_q <= '0;
			sticky_q <= ERR_NONE;
			maxp_q <= MAX_PKT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				maxp_q <= cfg_data;
			end
			if (emit_en) begin
				ctr_q <= ctr_d;
				sticky_q <= sticky_d;
				flush_q <= fin && !last_out;
				// The end of a stream clears everything but the stamp counter, the error and max_packet_bytes.
				if (last_out) begin
					win_q <= '0;
					fill_q <= '0;
					sas_q <= 1'b1;
					scl_q <= '0;
					pkt_q <= '0;
				end else begin
					win_q <= {8'h00, vw[WIN_BYTES-1:1]};
					fill_q <= vfill - 3'd1;
					sas_q <= sas_d;
					scl_q <= scl_d;
					pkt_q <= pkt_d;
				end
			end else if (accept) begin
				win_q <= vw;
				fill_q <= fill_q + 3'd1;
			end
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = res_q.data;
	assign unit_first = res_q.unit_first;
	assign unit_last = res_q.unit_last;
	assign packet_first = res_q.packet_first;
	assign packet_last = res_q.packet_last;
	assign unit_type = res_q.unit_type;
	assign has_stamp = res_q.has_stamp;
	assign stamp = res_q.stamp;
	assign error_code = res_q.error;
	assign stream_end = res_q.stream_end;
	assign run_last = res_q.run_last;

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 3'd4)
		else $error("lookahead window fill out of range");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q != ERR_NONE |=> sticky_q == $past(sticky_q))
		else $error("sticky error changed after being set");

	a_error_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.error != ERR_NONE |-> !res_q.unit_first && !res_q.has_stamp
			&& !res_q.packet_last)
		else $error("boundary marks given after a stream error");

	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.stream_end |-> res_q.run_last && !flush_q)
		else $error("stream end without end of run or with flush pending");
`endif

endmodule

/* test/annexb_nal_unit_splitter_test.sv */
// Self-checking testbench for the Annex B NAL unit splitter with its own byte-level predictor.
module annexb_nal_unit_splitter_test import nalsplit_pkg::*;;

	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned LONG_HOLD = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] in_byte = 8'h00;
	logic in_last = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [16:0] cfg_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_byte;
	logic unit_first;
	logic unit_last;
	logic packet_first;
	logic packet_last;
	logic [4:0] unit_type;
	logic has_stamp;
	logic [31:0] stamp;
	logic [1:0] error_code;
	logic stream_end;
	logic run_last;

	// Predictor state: lookahead window, unit tracking, packet count, stamp counter.
	logic [7:0] win [0:7] = '{default: 8'h00};
	int unsigned win_fill = 0;
	int unsigned code_left = 0;
	bit opens_unit = 1'b1;
	int unsigned pkt_bytes = 0;
	logic [31:0] frame_count = '0;
	err_code_t held_error = ERR_NONE;
	logic [16:0] max_pkt = MAX_PKT_RESET;

	res_t pending_results[$];
	logic [7:0] stream_buf[$];

	// Sender and receiver pacing.
	int unsigned gap_max = 0;
	int unsigned burst_left = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_done = 0;
	int unsigned hold_left = 0;
	int unsigned stall_cycle = 0;

	int unsigned bytes_sent = 0;
	int unsigned streams_sent = 0;
	int unsigned results_seen = 0;
	int unsigned units_seen = 0;
	int unsigned stamps_seen = 0;
	int unsigned packets_seen = 0;
	int unsigned mismatches = 0;
	int unsigned failures = 0;
	err_code_t err_kind = ERR_NONE;

	annexb_nal_unit_splitter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.unit_first(unit_first),
		.unit_last(unit_last),
		.packet_first(packet_first),
		.packet_last(packet_last),
		.unit_type(unit_type),
		.has_stamp(has_stamp),
		.stamp(stamp),
		.error_code(error_code),
		.stream_end(stream_end),
		.run_last(run_last)
	);

	always #10 clk = ~clk;

	function automatic int unsigned start_code_at(input int unsigned pos,
			input int unsigned avail);
		if (avail >= SC_LONG && win[pos] == 8'h00 && win[pos+1] == 8'h00
				&& win[pos+2] == 8'h00 && win[pos+3] == SC_MARK) begin
			return SC_LONG;
		end else if (avail >= SC_SHORT && win[pos] == 8'h00 && win[pos+1] == 8'h00
				&& win[pos+2] == SC_MARK) begin
			return SC_SHORT;
		end
		return SC_NONE;
	endfunction

	// Produces the result for the oldest window byte; avail counts the stream bytes
	// from it on.
	function automatic res_t emit_oldest(input int unsigned avail);
		res_t r;
		int unsigned len;
		int unsigned lim;
		bit broken;
		bit closes;
		r = '0;
		r.data = win[0];
		broken = 1'b0;
		closes = 1'b0;
		if (held_error == ERR_NONE) begin
			if (opens_unit) begin
				len = start_code_at(0, avail);
				if (len == 0) begin
					held_error = ERR_NO_START;
					broken = 1'b1;
				end else begin
					opens_unit = 1'b0;
					code_left = len;
					r.unit_first = 1'b1;
					if (avail > len)
						r.unit_type = win[len][4:0];
					if (r.unit_type == TYPE_NON_IDR || r.unit_type == TYPE_IDR) begin
						r.has_stamp = 1'b1;
						r.stamp = frame_count;
						frame_count = frame_count + 1;
					end
				end
			end
			if (!broken) begin
				if (code_left > 0) begin
					code_left--;
					if (code_left == 0) begin
						if (avail == 1) begin
							held_error = ERR_END_START;
							broken = 1'b1;
						end else if (start_code_at(1, avail - 1) != SC_NONE) begin
							held_error = ERR_ADJ_START;
							broken = 1'b1;
						end
					end
				end else if (avail == 1 || start_code_at(1, avail - 1) != SC_NONE) begin
					closes = 1'b1;
					opens_unit = 1'b1;
				end
			end
			if (broken) begin
				r.unit_first = 1'b0;
				r.unit_type = '0;
				r.has_stamp = 1'b0;
				r.stamp = '0;
			end else begin
				lim = (max_pkt == 0) ? 1 : max_pkt;
				r.unit_last = closes;
				r.packet_first = (pkt_bytes == 0);
				pkt_bytes++;
				if (pkt_bytes >= lim || closes) begin
					r.packet_last = 1'b1;
					pkt_bytes = 0;
				end
			end
		end
		r.error = held_error;
		for (int i = 0; i < WIN_BYTES - 1; i++)
			win[i] = win[i+1];
		win[WIN_BYTES-1] = 8'h00;
		if (win_fill > 0)
			win_fill--;
		return r;
	endfunction

	task automatic predict_byte(input logic [7:0] b, input logic fin);
		res_t r;
		if (win_fill < WIN_BYTES) begin
			win[win_fill] = b;
			win_fill++;
		end
		if (!fin) begin
			if (win_fill >= WIN_BYTES) begin
				r = emit_oldest(AHEAD);
				r.run_last = 1'b1;
				pending_results.push_back(r);
			end
		end else begin
			// The final byte flushes the whole window and opens a fresh stream.
			while (win_fill > 0) begin
				r = emit_oldest(win_fill);
				if (win_fill == 0) begin
					r.stream_end = 1'b1;
					r.run_last = 1'b1;
				end
				pending_results.push_back(r);
			end
			for (int i = 0; i < 8; i++)
				win[i] = 8'h00;
			code_left = 0;
			opens_unit = 1'b1;
			pkt_bytes = 0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= fin;
		do @(posedge clk); while (in_stall);
		predict_byte(b, fin);
		bytes_sent++;
	endtask

	task automatic send_stream();
		foreach (stream_buf[i])
			send_byte(stream_buf[i], i == stream_buf.size() - 1);
		stream_buf.delete();
		streams_sent++;
	endtask

	// Well-formed stream: every unit has a nonzero header, and zero bytes in the
	// payload only appear in runs that cannot form a start code.
	task automatic send_random_stream(input int unsigned units, input int unsigned longest);
		logic [7:0] hdr;
		int unsigned n;
		repeat (units) begin
			if ($urandom_range(1))
				stream_buf.push_back(8'h00);
			stream_buf.push_back(8'h00);
			stream_buf.push_back(8'h00);
			stream_buf.push_back(SC_MARK);
			hdr = 8'($urandom_range(255, 1));
			case ($urandom_range(3))
				0: hdr[4:0] = TYPE_NON_IDR;
				1: hdr[4:0] = TYPE_IDR;
				default: ;
			endcase
			stream_buf.push_back(hdr);
			n = $urandom_range(longest);
			repeat (n) begin
				if ($urandom_range(9) == 0) begin
					stream_buf.push_back(8'h00);
					stream_buf.push_back(8'h00);
					stream_buf.push_back($urandom_range(1) ? 8'h03 : 8'h02);
				end else begin
					stream_buf.push_back(8'($urandom_range(255, 1)));
				end
			end
		end
		send_stream();
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_max_packet(input logic [16:0] v);
		wait_all_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_pkt = v;
	endtask

	task automatic test_directed();
		gap_max = 0;
		stall_pct = 0;
		// Long start code with an IDR header, then a short one with a non-IDR header.
		stream_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'hFF, 8'h00, 8'h00, 8'h01,
			8'h41, 8'h80};
		send_stream();
		// Shorter than the window; type 21 must not be taken for type 5.
		stream_buf = '{8'h00, 8'h00, 8'h01, 8'h15};
		send_stream();
		stream_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h9F, 8'h00, 8'h00, 8'h03};
		send_stream();
		wait_all_results();
	endtask

	task automatic test_packet_lengths();
		logic [16:0] sizes [0:6];
		sizes = '{17'd1, 17'd0, 17'd2, 17'd3, 17'd65536, 17'd131071, 17'd7};
		gap_max = 3;
		stall_pct = 25;
		foreach (sizes[i]) begin
			set_max_packet(sizes[i]);
			send_random_stream(2, 12);
		end
		wait_all_results();
	endtask

	task automatic test_random_traffic();
		int unsigned first_sent;
		first_sent = bytes_sent;
		while (bytes_sent - first_sent < 110) begin
			if ($urandom_range(4) == 0) begin
				case ($urandom_range(5))
					0: set_max_packet(17'd0);
					1: set_max_packet(MAX_PKT_RESET);
					2: set_max_packet(17'd131071);
					default: set_max_packet(17'($urandom_range(9, 1)));
				endcase
			end
			case ($urandom_range(3))
				0: gap_max = 0;
				1: gap_max = 2;
				default: gap_max = 8;
			endcase
			stall_pct = $urandom_range(2) * 25;
			send_random_stream($urandom_range(4, 1), $urandom_range(1) ? 6 : 24);
		end
		wait_all_results();
	endtask

	task automatic test_backpressure();
		gap_max = 0;
		stall_pct = 0;
		set_max_packet(17'd5);
		// The receiver holds off while bytes keep coming, so the input has to stall.
		hold_requests++;
		send_random_stream(4, 10);
		wait_all_results();
		send_random_stream(2, 6);
		wait_all_results();
	endtask

	// The error is sticky until reset, so only one kind can be driven per run.
	task automatic test_stream_errors();
		gap_max = 2;
		stall_pct = 25;
		err_kind = err_code_t'($urandom_range(3, 1));
		case (err_kind)
			ERR_NO_START:
				stream_buf = '{8'h00, 8'h00, 8'h02, 8'h41, 8'hFF, 8'h00};
			ERR_END_START:
				stream_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'h00, 8'h00,
					8'h00, 8'h01};
			default:
				stream_buf = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65,
					8'h88, 8'h99};
		endcase
		send_stream();
		// Bytes must still pass through once the error is latched.
		repeat (3) begin
			repeat ($urandom_range(14, 1))
				stream_buf.push_back(8'(($urandom_range(2) == 0) ? 0 : $urandom_range(255)));
			send_stream();
		end
		wait_all_results();
	endtask

	always @(posedge clk) begin
		stall_cycle++;
		if (holds_done != hold_requests) begin
			holds_done++;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if ((stall_cycle / 53) % 3 == 0) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		string diffs;
		if (out_valid && !out_stall) begin
			got.data = out_byte;
			got.unit_first = unit_first;
			got.unit_last = unit_last;
			got.packet_first = packet_first;
			got.packet_last = packet_last;
			got.unit_type = unit_type;
			got.has_stamp = has_stamp;
			got.stamp = stamp;
			got.error = err_code_t'(error_code);
			got.stream_end = stream_end;
			got.run_last = run_last;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected transaction: out_byte %02h with nothing pending",
						out_byte);
			end else begin
				want = pending_results.pop_front();
				diffs = "";
				if (got.data !== want.data)
					diffs = {diffs, $sformatf(" out_byte %02h/%02h", want.data, got.data)};
				if (got.unit_first !== want.unit_first)
					diffs = {diffs, $sformatf(" unit_first %b/%b", want.unit_first,
						got.unit_first)};
				if (got.unit_last !== want.unit_last)
					diffs = {diffs, $sformatf(" unit_last %b/%b", want.unit_last,
						got.unit_last)};
				if (got.packet_first !== want.packet_first)
					diffs = {diffs, $sformatf(" packet_first %b/%b", want.packet_first,
						got.packet_first)};
				if (got.packet_last !== want.packet_last)
					diffs = {diffs, $sformatf(" packet_last %b/%b", want.packet_last,
						got.packet_last)};
				if (got.unit_type !== want.unit_type)
					diffs = {diffs, $sformatf(" unit_type %0d/%0d", want.unit_type,
						got.unit_type)};
				if (got.has_stamp !== want.has_stamp)
					diffs = {diffs, $sformatf(" has_stamp %b/%b", want.has_stamp,
						got.has_stamp)};
				if (got.stamp !== want.stamp)
					diffs = {diffs, $sformatf(" stamp %0d/%0d", want.stamp, got.stamp)};
				if (got.error !== want.error)
					diffs = {diffs, $sformatf(" error_code %0d/%0d", want.error,
						got.error)};
				if (got.stream_end !== want.stream_end)
					diffs = {diffs, $sformatf(" stream_end %b/%b", want.stream_end,
						got.stream_end)};
				if (got.run_last !== want.run_last)
					diffs = {diffs, $sformatf(" run_last %b/%b", want.run_last,
						got.run_last)};
				if (diffs != "") begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch on result %0d (expected/actual):%s",
							results_seen, diffs);
				end
				results_seen++;
				if (want.unit_first)
					units_seen++;
				if (want.has_stamp)
					stamps_seen++;
				if (want.packet_last)
					packets_seen++;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_packet_lengths();
		test_random_traffic();
		test_backpressure();
		test_stream_errors();
		wait_all_results();
		repeat (20) @(posedge clk);
		failures = mismatches + pending_results.size();
		$display("Checked %0d results from %0d bytes in %0d streams: %0d units, %0d stamped,",
			results_seen, bytes_sent, streams_sent, units_seen, stamps_seen);
		$display("%0d packets, packet limits 0 to 131071, ending in the %s state.",
			packets_seen, err_kind.name());
		if (failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
